[rtl/daq_event_word_unpacker_defines.svh]
// Assertion macros shared by the unpacker RTL.
`ifndef DAQ_EVENT_WORD_UNPACKER_DEFINES_SVH
`define DAQ_EVENT_WORD_UNPACKER_DEFINES_SVH

`ifndef SYNTH

// Checked only while out of reset.
`define DEU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define DEU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DEU_ASSERT(lbl, clk, rst_n, prop, msg)
`define DEU_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/deu_pkg.sv]
`default_nettype none

package deu_pkg;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_COUNT,
		PH_SKIP,
		PH_BODY
	} phase_t;

	typedef enum logic [2:0] {
		KIND_LEAD,
		KIND_TRAIL,
		KIND_ADC_HI,
		KIND_ADC_LO,
		KIND_END
	} kind_t;

	localparam logic [31:0] HEADER_RESET = 32'hffff_ea0c;
	localparam logic [7:0]  TYPE_TDC     = 8'hcc;
	localparam logic [7:0]  TYPE_ADC_HI  = 8'h81;
	localparam logic [7:0]  TYPE_ADC_LO  = 8'h60;

	localparam int unsigned IDX_MAX = 15;

endpackage

`default_nettype wire

[rtl/deu_ram.sv]
`default_nettype none

module deu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-first: a read at the write address returns the old contents
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/daq_event_word_unpacker.sv]
// Readout-word unpacker. One 32-bit word is taken every clock at full rate;
// results pass through the decode stage and the output register, and
// back-pressure on the result side stalls the input only once both are held.
// A header word (header_word register) opens an event, the next word gives the
// body length and the one after it is skipped. TDC body words look up and bump
// a per-channel hit count kept in a small RAM of NUM_CHANNELS rows (leading and
// trailing count side by side, registered read): the count is read when the
// word is taken and written back as the word leaves the decode stage, with the
// last write forwarded to a word on the same channel that follows directly.
// Per-row valid flags clear every count in the cycle that takes the header, so
// there is no clearing pass. The user writes header_word only while the block
// is idle; the block itself does not enforce this.
`default_nettype none
`include "daq_event_word_unpacker_defines.svh"

module daq_event_word_unpacker
	import deu_pkg::*;
#(
	parameter int unsigned NUM_CHANNELS = 32,
	parameter int unsigned MAX_HITS     = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,      // header_word

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] data_word

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [7:0] channel, [19:8] value, [23:20] hit_index
	output logic [3:0]       m_axis_tuser,  // [2:0] hit_kind, [3] overflow
	output logic             m_axis_tlast   // last_of_event
);

	localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int unsigned CW = $clog2(MAX_HITS + 1);
	localparam int unsigned RW = 2 * CW;

	// configuration
	logic [31:0] header_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg_valid) begin
			header_q <= cfg_data;
		end
	end

	// handshake
	logic s1_valid_s1;
	logic out_valid_q;
	logic s1_move;
	logic accept;

	assign s1_move       = !s1_valid_s1 || !out_valid_q || m_axis_tready;
	assign s_axis_tready = s1_move;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// word decode and framing
	phase_t      phase_q, phase_d;
	logic [15:0] words_left_q, words_left_d;
	logic        hdr_clear;
	logic        res_d;
	kind_t       kind_d;
	logic        last_d;
	logic        tdc_d;
	logic        ovf_d;

	logic [7:0]  w_type;
	logic [7:0]  w_ch;
	logic [11:0] w_val;
	logic        w_inrange;
	logic [15:0] left_dec;

	assign w_type    = s_axis_tdata[31:24];
	assign w_ch      = s_axis_tdata[23:16];
	assign w_val     = s_axis_tdata[11:0];
	assign w_inrange = {1'b0, w_ch} < 9'(NUM_CHANNELS);
	assign left_dec  = words_left_q - 16'd1;

	always_comb begin
		phase_d      = phase_q;
		words_left_d = words_left_q;
		hdr_clear    = 1'b0;
		res_d        = 1'b0;
		kind_d       = KIND_END;
		last_d       = 1'b0;
		tdc_d        = 1'b0;
		ovf_d        = 1'b0;
		unique case (phase_q)
			PH_WAIT: begin
				if (s_axis_tdata == header_q) begin
					hdr_clear = 1'b1;
					phase_d   = PH_COUNT;
				end
			end
			PH_COUNT: begin
				words_left_d = s_axis_tdata[15:0];
				phase_d      = PH_SKIP;
			end
			PH_SKIP: begin
				if (words_left_q == 16'd0) begin
					phase_d = PH_WAIT;
					res_d   = 1'b1;
					last_d  = 1'b1;
				end else begin
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				words_left_d = left_dec;
				last_d       = (left_dec == 16'd0);
				if (last_d) begin
					phase_d = PH_WAIT;
				end
				priority if (w_type == TYPE_TDC) begin
					res_d  = 1'b1;
					tdc_d  = 1'b1;
					kind_d = s_axis_tdata[15] ? KIND_TRAIL : KIND_LEAD;
					ovf_d  = !w_inrange;
				end else if (w_type == TYPE_ADC_HI || w_type == TYPE_ADC_LO) begin
					res_d  = 1'b1;
					kind_d = (w_type == TYPE_ADC_HI) ? KIND_ADC_HI : KIND_ADC_LO;
					ovf_d  = !w_inrange;
				end else begin
					res_d = last_d;
				end
			end
			default: begin
				phase_d = PH_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			words_left_q <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			words_left_q <= words_left_d;
		end
	end

	// hit count stage
	kind_t       kind_s1;
	logic [7:0]  ch_s1;
	logic [11:0] val_s1;
	logic        last_s1;
	logic        tdc_s1;
	logic        ovf_s1;
	logic        fwd_s1;

	logic [RW-1:0]   ram_rdata;
	logic            ram_we;
	logic [RW-1:0]   row_new;
	logic [RW-1:0]   wr_data_q;
	logic [AW-1:0]   ch_addr_s1;
	logic [AW-1:0]   in_addr;
	logic [NUM_CHANNELS-1:0] row_valid_q;

	logic [RW-1:0] row_cur;
	logic [CW-1:0] cnt;
	logic [7:0]    cnt8;
	logic          full;
	logic          hit_ok;
	logic [3:0]    idx;

	assign in_addr    = w_ch[AW-1:0];
	assign ch_addr_s1 = ch_s1[AW-1:0];

	always_comb begin
		if (fwd_s1) begin
			row_cur = wr_data_q;
		end else if (row_valid_q[ch_addr_s1]) begin
			row_cur = ram_rdata;
		end else begin
			row_cur = '0;
		end
		cnt    = (kind_s1 == KIND_TRAIL) ? row_cur[RW-1:CW] : row_cur[CW-1:0];
		cnt8   = 8'(cnt);
		full   = cnt8 >= 8'(MAX_HITS);
		hit_ok = tdc_s1 && !ovf_s1 && !full;
		idx    = !hit_ok ? 4'd0 : (cnt8 > 8'(IDX_MAX)) ? 4'(IDX_MAX) : cnt8[3:0];
		row_new = row_cur;
		if (kind_s1 == KIND_TRAIL) begin
			row_new[RW-1:CW] = CW'(cnt + 1'b1);
		end else begin
			row_new[CW-1:0] = CW'(cnt + 1'b1);
		end
	end

	assign ram_we = s1_valid_s1 && s1_move && hit_ok;

	deu_ram #(
		.WIDTH (RW),
		.DEPTH (NUM_CHANNELS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_addr_s1),
		.wdata (row_new),
		.re    (accept),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			fwd_s1      <= 1'b0;
		end else if (s1_move) begin
			s1_valid_s1 <= accept && res_d;
			fwd_s1      <= ram_we && (ch_addr_s1 == in_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			kind_s1 <= kind_d;
			ch_s1   <= (kind_d == KIND_END) ? 8'd0 : w_ch;
			val_s1  <= (kind_d == KIND_END) ? 12'd0 : w_val;
			last_s1 <= last_d;
			tdc_s1  <= tdc_d;
			ovf_s1  <= ovf_d;
		end
		if (ram_we) begin
			wr_data_q <= row_new;
		end
	end

	// a header clears every row at once; this wins over a write-back in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (accept && hdr_clear) begin
			row_valid_q <= '0;
		end else if (ram_we) begin
			row_valid_q[ch_addr_s1] <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1 && (!out_valid_q || m_axis_tready)) begin
			m_axis_tdata <= {idx, val_s1, ch_s1};
			m_axis_tuser <= {ovf_s1 || (tdc_s1 && full), kind_s1};
			m_axis_tlast <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;

	`DEU_ASSERT(a_we_needs_item, clk, arst_n,
		ram_we |-> (s1_valid_s1 && tdc_s1), "count written without a tdc word in the stage")
	`DEU_ASSERT(a_hdr_clears, clk, arst_n,
		(accept && hdr_clear) |=> (row_valid_q == '0), "header did not clear the hit counts")
	`DEU_ASSERT(a_end_clean, clk, arst_n,
		(m_axis_tvalid && m_axis_tuser[2:0] == KIND_END) |-> (m_axis_tlast && !m_axis_tuser[3]),
		"event end result malformed")
	`DEU_ASSERT(a_idx_tdc_only, clk, arst_n,
		(m_axis_tvalid && m_axis_tdata[23:20] != 4'd0) |->
		((m_axis_tuser[2:0] == KIND_LEAD || m_axis_tuser[2:0] == KIND_TRAIL)
		&& !m_axis_tuser[3]), "hit index on a result that is not a counted tdc hit")
	`DEU_ASSERT_ALWAYS(a_fwd_after_write, clk,
		(arst_n && fwd_s1) |-> ($past(ram_we) || ($past(fwd_s1) && !$past(s1_move))),
		"forwarding without a preceding write")

endmodule

`default_nettype wire
